FILE: src/eld_pkg.sv
// Types, character codes and helper functions shared by the escaped line decoder.
package eld_pkg;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_END   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_ESCAPE = 2'd1,
		PH_HEX_HI = 2'd2,
		PH_HEX_LO = 2'd3
	} phase_t;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_X         = 8'h78;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] high_nibble;
		logic       has_data;
		logic       skipping;
		logic       halted;
	} dec_state_t;

	localparam dec_state_t STATE_RESET = '{
		phase:       PH_NORMAL,
		high_nibble: 4'h0,
		has_data:    1'b0,
		skipping:    1'b0,
		halted:      1'b0
	};

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] value;
	} step_res_t;

	// {is_hex, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] d;
		logic [4:0] r;
		d = 8'h00;
		r = 5'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			r = {1'b1, d[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			r = {1'b1, d[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			r = {1'b1, d[3:0]};
		end
		return r;
	endfunction

endpackage

FILE: src/eld_stream_if.sv
// Valid/ready channel interfaces for raw input bytes and decoded results.
interface eld_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_input;

	modport source(output valid, output byte_in, output end_of_input, input ready);
	modport sink(input valid, input byte_in, input end_of_input, output ready);
endinterface

interface eld_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] value;

	modport source(output valid, output kind, output value, input ready);
	modport sink(input valid, input kind, input value, output ready);
endinterface

FILE: src/eld_step.sv
// Per-byte decode step: next decoder state and the optional result for one item.
module eld_step (
	input  eld_pkg::dec_state_t state,
	input  logic [7:0]          byte_in,
	input  logic                end_of_input,
	output eld_pkg::dec_state_t state_nxt,
	output eld_pkg::step_res_t  res
);
	import eld_pkg::*;

	logic       data_go;
	logic       close_go;
	logic       err_go;
	logic [7:0] data_byte;
	logic [4:0] hex;
	logic       skip_new;

	assign hex = hex_decode(byte_in);

	always_comb begin
		data_go   = 1'b0;
		close_go  = 1'b0;
		err_go    = 1'b0;
		data_byte = byte_in;
		state_nxt = state;
		res       = '{valid: 1'b0, kind: KIND_DATA, value: 8'h00};
		skip_new  = state.skipping;

		if (end_of_input) begin
			if (!state.halted) begin
				if (state.phase != PH_NORMAL) begin
					err_go = 1'b1;
				end else begin
					close_go = 1'b1;
				end
			end
		end else if (!state.halted) begin
			case (state.phase)
				PH_NORMAL: begin
					if (byte_in == CH_NEWLINE) begin
						close_go = 1'b1;
					end else if (byte_in == CH_BACKSLASH) begin
						state_nxt.phase = PH_ESCAPE;
					end else begin
						data_go = 1'b1;
					end
				end
				PH_ESCAPE: begin
					state_nxt.phase = PH_NORMAL;
					if (byte_in == CH_N) begin
						data_go   = 1'b1;
						data_byte = CH_NEWLINE;
					end else if (byte_in == CH_T) begin
						data_go   = 1'b1;
						data_byte = CH_TAB;
					end else if (byte_in == CH_BACKSLASH) begin
						data_go   = 1'b1;
						data_byte = CH_BACKSLASH;
					end else if (byte_in == CH_R) begin
						data_go = 1'b0;
					end else if (byte_in == CH_X) begin
						state_nxt.phase = PH_HEX_HI;
					end else begin
						err_go = 1'b1;
					end
				end
				PH_HEX_HI: begin
					if (!hex[4]) begin
						err_go = 1'b1;
					end else begin
						state_nxt.high_nibble = hex[3:0];
						state_nxt.phase       = PH_HEX_LO;
					end
				end
				PH_HEX_LO: begin
					if (!hex[4]) begin
						err_go = 1'b1;
					end else begin
						state_nxt.phase = PH_NORMAL;
						data_go         = 1'b1;
						data_byte       = {state.high_nibble, hex[3:0]};
					end
				end
				default: begin
					err_go = 1'b1;
				end
			endcase
		end

		// first decoded byte of an entry decides whether it is a comment
		if (data_go) begin
			skip_new           = state.skipping |
			                     (!state.has_data && (data_byte == CH_HASH));
			state_nxt.has_data = 1'b1;
			state_nxt.skipping = skip_new;
			if (!skip_new) begin
				res = '{valid: 1'b1, kind: KIND_DATA, value: data_byte};
			end
		end

		if (close_go) begin
			state_nxt.has_data = 1'b0;
			state_nxt.skipping = 1'b0;
			if (state.has_data && !state.skipping) begin
				res = '{valid: 1'b1, kind: KIND_END, value: 8'h00};
			end
		end

		if (err_go) begin
			state_nxt.halted = 1'b1;
			state_nxt.phase  = PH_NORMAL;
			res = '{valid: 1'b1, kind: KIND_ERROR, value: 8'h00};
		end

		// end of input always leaves a clean decoder for the next file
		if (end_of_input) begin
			state_nxt = STATE_RESET;
		end
	end

endmodule

FILE: src/escaped_line_decoder_unit.sv
// Accepted items pass through an input register, then a result register; one item per cycle
// while results are taken. Items that decode to no result are absorbed silently.
// The result register doubles as the buffer that lets input flow while a result waits.
// Reset (arst_n low, asynchronous): clears both valid flags and the decoder state,
// so the block starts in normal text with no entry open and no error latched.
module escaped_line_decoder_unit (
	input logic       clk,
	input logic       arst_n,
	eld_in_if.sink    bytes,
	eld_out_if.source results
);
	import eld_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;
	logic       adv_s1;
	dec_state_t state_q;
	dec_state_t state_nxt;
	step_res_t  res;
	logic       valid_s2;
	kind_t      kind_s2;
	logic [7:0] value_s2;

	assign adv_s1      = valid_s1 && (!valid_s2 || results.ready);
	assign bytes.ready = !valid_s1 || adv_s1;

	eld_step u_step (
		.state        (state_q),
		.byte_in      (byte_s1),
		.end_of_input (eoi_s1),
		.state_nxt    (state_nxt),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (bytes.valid && bytes.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				state_q  <= state_nxt;
				valid_s2 <= res.valid;
			end else if (results.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.byte_in;
			eoi_s1  <= bytes.end_of_input;
		end
		if (adv_s1) begin
			kind_s2  <= res.kind;
			value_s2 <= res.value;
		end
	end

	assign results.valid = valid_s2;
	assign results.kind  = kind_s2;
	assign results.value = value_s2;

endmodule

FILE: src/eld_checker.sv
// Port-level checker for the escaped line decoder, bound to the top level.
module eld_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_value
);
	import eld_pkg::*;

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_END ||
		               out_kind == KIND_ERROR))
		else $error("result kind out of range");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind != KIND_DATA) |-> (out_value == 8'h00))
		else $error("marker or error item carries nonzero value");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(out_kind) && $stable(out_value)))
		else $error("result payload changed while stalled");

endmodule

bind escaped_line_decoder_unit eld_checker u_eld_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_kind  (results.kind),
	.out_value (results.value)
);

FILE: verif/tb_escaped_line_decoder_unit.sv
// Self-checking testbench for the escaped line decoder: directed escapes, errors, stalls, random files.
`timescale 1ns / 1ps

module tb_escaped_line_decoder_unit;
	import eld_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 10;
	localparam int RANDOM_ITEMS   = 1100;
	localparam int STALL_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_REPORTS    = 10;

	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef struct {
		kind_t      kind;
		logic [7:0] value;
	} dec_result_t;

	typedef logic [7:0] byte_seq_t[$];

	logic clk = 1'b0;
	logic arst_n;

	eld_in_if  in_ch();
	eld_out_if out_ch();

	escaped_line_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(in_ch),
		.results(out_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// decoder state as predicted from accepted items
	phase_t     m_phase;
	logic [3:0] m_hi;
	bit         m_has_data;
	bit         m_skip;
	bit         m_halt;

	dec_result_t decoded_q[$];
	dec_result_t head_r;

	int  error_count;
	int  items_sent;
	int  data_seen;
	int  end_seen;
	int  error_seen;
	int  idle_cycles;
	bit  tx_fast;
	bit  rx_fast;
	int  rx_hold;

	function automatic void note_error(string what);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, what);
	endfunction

	function automatic void clear_model();
		m_phase    = PH_NORMAL;
		m_hi       = 4'h0;
		m_has_data = 1'b0;
		m_skip     = 1'b0;
		m_halt     = 1'b0;
	endfunction

	function automatic void expect_result(kind_t kind, logic [7:0] value);
		decoded_q.push_back('{kind, value});
	endfunction

	function automatic int hex_nibble(logic [7:0] c);
		if (c inside {[8'h30:8'h39]})
			return int'(c - CH_DIGIT_0);
		if (c inside {[8'h41:8'h46]})
			return int'(c - CH_UPPER_A) + 10;
		if (c inside {[8'h61:8'h66]})
			return int'(c - CH_LOWER_A) + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
		if (nib < 4'd10)
			return CH_DIGIT_0 + 8'(nib);
		return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(nib) - 8'd10;
	endfunction

	function automatic void flag_format_error();
		m_halt  = 1'b1;
		m_phase = PH_NORMAL;
		expect_result(KIND_ERROR, 8'h00);
	endfunction

	// first decoded byte of an entry decides whether it is a comment
	function automatic void take_data(logic [7:0] d);
		if (!m_has_data) begin
			m_has_data = 1'b1;
			if (d == CH_HASH)
				m_skip = 1'b1;
		end
		if (!m_skip)
			expect_result(KIND_DATA, d);
	endfunction

	function automatic void close_entry();
		if (m_has_data && !m_skip)
			expect_result(KIND_END, 8'h00);
		m_has_data = 1'b0;
		m_skip     = 1'b0;
	endfunction

	function automatic void decode_step(logic [7:0] c, logic eoi);
		int h;
		h = hex_nibble(c);
		if (eoi) begin
			if (!m_halt) begin
				if (m_phase != PH_NORMAL)
					flag_format_error();
				else
					close_entry();
			end
			clear_model();
			return;
		end
		if (m_halt)
			return;
		case (m_phase)
			PH_NORMAL: begin
				if (c == CH_NEWLINE)
					close_entry();
				else if (c == CH_BACKSLASH)
					m_phase = PH_ESCAPE;
				else
					take_data(c);
			end
			PH_ESCAPE: begin
				m_phase = PH_NORMAL;
				case (c)
					CH_N:         take_data(CH_NEWLINE);
					CH_T:         take_data(CH_TAB);
					CH_BACKSLASH: take_data(CH_BACKSLASH);
					CH_R:         ;
					CH_X:         m_phase = PH_HEX_HI;
					default:      flag_format_error();
				endcase
			end
			PH_HEX_HI: begin
				if (h < 0) begin
					flag_format_error();
				end else begin
					m_hi    = 4'(h);
					m_phase = PH_HEX_LO;
				end
			end
			default: begin
				if (h < 0) begin
					flag_format_error();
				end else begin
					m_phase = PH_NORMAL;
					take_data({m_hi, 4'(h)});
				end
			end
		endcase
	endfunction

	// Entered and left at a falling edge; valid stays high when the next item follows at once.
	task automatic push_byte(logic [7:0] b, logic eoi);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.byte_in      <= b;
		in_ch.end_of_input <= eoi;
		do @(posedge clk); while (!in_ch.ready);
		decode_step(b, eoi);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_seq(byte_seq_t seq, bit end_file);
		foreach (seq[i])
			push_byte(seq[i], 1'b0);
		if (end_file)
			push_byte(8'($urandom), 1'b1);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_basic_escapes();
		send_seq('{8'hFF, CH_BACKSLASH, CH_N, CH_BACKSLASH, CH_T, CH_BACKSLASH, CH_BACKSLASH,
			CH_BACKSLASH, CH_R, CH_BACKSLASH, CH_X, CH_LOWER_A, 8'h46, CH_NEWLINE}, 1'b0);
	endtask

	// comment entry, empty entry, then a zero byte closed by end of file
	task automatic test_entry_closing();
		send_seq('{CH_HASH, CH_NEWLINE, CH_NEWLINE, 8'h00}, 1'b1);
	endtask

	task automatic test_format_errors();
		send_seq('{CH_BACKSLASH}, 1'b1);
		send_seq('{CH_BACKSLASH, CH_NEWLINE}, 1'b1);
		// bad hex digit inside a comment entry, then a byte dropped while halted
		send_seq('{CH_HASH, CH_BACKSLASH, CH_X, 8'h47, CH_LOWER_A}, 1'b1);
	endtask

	task automatic test_output_stall();
		tx_fast = 1'b1;
		rx_hold = STALL_CYCLES;
		for (int i = 0; i < 40; i++)
			push_byte(CH_SPACE + 8'(i), 1'b0);
		push_byte(CH_NEWLINE, 1'b0);
		drain_results();
		tx_fast = 1'b0;
	endtask

	task automatic send_random_entry();
		int ntok;
		int pick;
		logic [7:0] v;
		ntok = $urandom_range(0, 10);
		if ($urandom_range(0, 9) == 0)
			push_byte(CH_HASH, 1'b0);
		for (int i = 0; i < ntok && !m_halt; i++) begin
			pick = $urandom_range(0, 99);
			v = 8'($urandom);
			if (pick < 45) begin
				while (v == CH_NEWLINE || v == CH_BACKSLASH)
					v = 8'($urandom);
				push_byte(v, 1'b0);
			end else if (pick < 55) begin
				send_seq('{CH_BACKSLASH, CH_N}, 1'b0);
			end else if (pick < 62) begin
				send_seq('{CH_BACKSLASH, CH_T}, 1'b0);
			end else if (pick < 69) begin
				send_seq('{CH_BACKSLASH, CH_BACKSLASH}, 1'b0);
			end else if (pick < 74) begin
				send_seq('{CH_BACKSLASH, CH_R}, 1'b0);
			end else if (pick < 90) begin
				send_seq('{CH_BACKSLASH, CH_X, hex_char(v[7:4], 1'($urandom)),
					hex_char(v[3:0], 1'($urandom))}, 1'b0);
			end else if (pick < 94) begin
				push_byte(v, 1'b0);
			end else if (pick < 97) begin
				send_seq('{CH_BACKSLASH, v}, 1'b0);
			end else if (pick < 99) begin
				send_seq('{CH_BACKSLASH, CH_X, v, 8'($urandom)}, 1'b0);
			end else begin
				// leave an escape open for the terminator to hit
				push_byte(CH_BACKSLASH, 1'b0);
				break;
			end
		end
		if (m_halt) begin
			repeat ($urandom_range(0, 2))
				push_byte(8'($urandom), 1'b0);
			push_byte(8'($urandom), 1'b1);
		end else if ($urandom_range(0, 7) == 0) begin
			push_byte(8'($urandom), 1'b1);
		end else begin
			push_byte(CH_NEWLINE, 1'b0);
		end
	endtask

	task automatic test_random_files();
		int first;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			tx_fast = ($urandom_range(0, 7) == 0);
			rx_fast = ($urandom_range(0, 7) == 0);
			send_random_entry();
			if ($urandom_range(0, 24) == 0)
				drain_results();
		end
		tx_fast = 1'b0;
		rx_fast = 1'b0;
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold > 0) begin
				out_ch.ready <= 1'b0;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end
			gap = rx_fast ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (decoded_q.size() == 0) begin
				note_error($sformatf("unexpected result kind %0d value 0x%02h",
					out_ch.kind, out_ch.value));
			end else begin
				head_r = decoded_q.pop_front();
				case (head_r.kind)
					KIND_DATA: data_seen++;
					KIND_END:  end_seen++;
					default:   error_seen++;
				endcase
				if (out_ch.kind !== head_r.kind || out_ch.value !== head_r.value)
					note_error($sformatf("expected kind %0d value 0x%02h, got kind %0d value 0x%02h",
						head_r.kind, head_r.value, out_ch.kind, out_ch.value));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.byte_in      = 8'h00;
		in_ch.end_of_input = 1'b0;
		idle_cycles        = 0;
		tx_fast            = 1'b0;
		rx_fast            = 1'b0;
		rx_hold            = 0;
		clear_model();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_escapes();
		test_entry_closing();
		test_format_errors();
		test_output_stall();
		test_random_files();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (decoded_q.size() != 0)
			note_error($sformatf("%0d results never arrived", decoded_q.size()));

		$display("Sent %0d input items; checked %0d data, %0d end-of-entry, %0d format-error results",
			items_sent, data_seen, end_seen, error_seen);
		$display("Covered all escapes, comment and empty entries, halts, and a %0d-cycle output stall",
			STALL_CYCLES);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
